// ----- src/fls_pkg.sv -----
// Shared types and constants of the fixed-length frame synchronizer.
// Used by the front stage, the decoupling queue and the back end; no dependencies.
package fls_pkg;

	localparam logic [7:0] STAR_CHAR  = 8'h2A;
	localparam logic [7:0] SPACE_CHAR = 8'h20;
	localparam logic [7:0] CR_CHAR    = 8'h0D;
	localparam logic [7:0] LF_CHAR    = 8'h0A;

	localparam int QUEUE_DEPTH = 4;

	typedef struct packed {
		logic [7:0] data;
		logic       is_star;
		logic       is_space;
		logic       is_cr;
		logic       is_lf;
	} byte_class_t;

endpackage

// ----- src/fls_if.sv -----
// Valid/ready channel interfaces of the frame synchronizer: received bytes in,
// validated frame bytes out. No dependencies.
interface fls_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source(output valid, output data_byte, input ready);
	modport sink(input valid, input data_byte, output ready);
endinterface

interface fls_frame_if;
	logic        valid;
	logic        ready;
	logic [7:0]  frame_byte;
	logic        last_byte;
	logic [31:0] good_frames;
	logic [31:0] error_count;
	logic [31:0] frame_offset;

	modport source(output valid, output frame_byte, output last_byte, output good_frames,
		output error_count, output frame_offset, input ready);
	modport sink(input valid, input frame_byte, input last_byte, input good_frames,
		input error_count, input frame_offset, output ready);
endinterface

// ----- src/fls_fifo.sv -----
// Short queue of classified bytes between the front stage and the back end.
// Depends on fls_pkg for the entry type.
module fls_fifo #(
	parameter int DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	output logic                push_ready,
	input  fls_pkg::byte_class_t push_data,
	output logic                pop_valid,
	input  logic                pop_ready,
	output fls_pkg::byte_class_t pop_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_P = PW'(DEPTH - 1);
	localparam logic [NW-1:0] FULL_N = NW'(DEPTH);

	fls_pkg::byte_class_t entry_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [NW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready = (count_q != FULL_N);
	assign pop_valid  = (count_q != '0);
	assign pop_data   = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_P) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_P) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!do_push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ----- src/fls_front.sv -----
// Front stage: takes each received byte and tags it as star, space, CR or LF.
// Depends on fls_pkg and the fls_byte_if interface.
module fls_front (
	input  logic                 clk,
	input  logic                 arst_n,
	fls_byte_if.sink             rx,
	output logic                 q_valid,
	input  logic                 q_ready,
	output fls_pkg::byte_class_t q_data
);

	logic                 vld_s1;
	fls_pkg::byte_class_t cls_s1;
	logic                 take;

	assign rx.ready = !vld_s1 || q_ready;
	assign take     = rx.valid && rx.ready;
	assign q_valid  = vld_s1;
	assign q_data   = cls_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (rx.ready) begin
			vld_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cls_s1.data     <= rx.data_byte;
			cls_s1.is_star  <= (rx.data_byte == fls_pkg::STAR_CHAR);
			cls_s1.is_space <= (rx.data_byte == fls_pkg::SPACE_CHAR);
			cls_s1.is_cr    <= (rx.data_byte == fls_pkg::CR_CHAR);
			cls_s1.is_lf    <= (rx.data_byte == fls_pkg::LF_CHAR);
		end
	end

endmodule

// ----- src/fls_back.sv -----
// Back end: ring buffer memory, frame judgment by a scan over the memory, and
// emission of valid frames through a two-entry output buffer.
// Depends on fls_pkg and the fls_frame_if interface.
module fls_back #(
	parameter int FRAME_LEN = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	output logic                 q_ready,
	input  fls_pkg::byte_class_t q_data,
	fls_frame_if.source          tx
);

	localparam int IW = $clog2(FRAME_LEN);
	localparam int CW = $clog2(FRAME_LEN + 1);
	localparam logic [IW-1:0] LAST_I  = IW'(FRAME_LEN - 1);
	localparam logic [CW-1:0] LEN_C   = CW'(FRAME_LEN);
	localparam logic [CW-1:0] LAST_C  = CW'(FRAME_LEN - 1);
	localparam logic [31:0]   LEN_32  = 32'(FRAME_LEN);

	typedef enum logic [1:0] {ST_RUN, ST_WAIT, ST_SCAN} state_t;
	typedef enum logic [1:0] {PH_FIRST, PH_LEAD, PH_NEXT} phase_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} out_ent_t;

	logic [9:0] mem [FRAME_LEN];

	state_t        st_q;
	phase_t        phase_q;
	logic [IW-1:0] wp_q;
	logic [CW-1:0] fill_q;
	logic [31:0]   pos_q;
	logic [31:0]   good_q;
	logic [31:0]   err_q;
	logic [31:0]   off_q;
	logic          prev_cr_q;
	logic          end_ok_q;

	logic [CW-1:0] scan_idx_q;
	logic [IW-1:0] scan_addr_q;

	logic          em_act_q;
	logic [CW-1:0] em_cnt_q;
	logic [IW-1:0] em_addr_q;

	logic          rd_v_s1;
	logic          rd_emit_s1;
	logic          rd_last_s1;
	logic [IW-1:0] rd_idx_s1;
	logic [9:0]    rd_data_s1;

	out_ent_t      ofifo_q [2];
	logic          owp_q;
	logic          orp_q;
	logic [1:0]    ocnt_q;

	logic          pop;
	logic          scan_issue;
	logic          em_issue;
	logic          rd_en;
	logic [IW-1:0] rd_addr;
	logic          res_scan;
	logic          d_star;
	logic          d_space;
	logic          opush;
	logic          opop;
	logic [2:0]    occ;

	function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] a);
		return (a == LAST_I) ? '0 : a + 1'b1;
	endfunction

	assign q_ready    = (st_q == ST_RUN) && (!em_act_q || (fill_q < em_cnt_q));
	assign pop        = q_valid && q_ready;
	assign scan_issue = (st_q == ST_SCAN) && (scan_idx_q < LEN_C);
	assign opush      = rd_v_s1 && rd_emit_s1;
	assign opop       = tx.valid && tx.ready;
	assign occ        = {1'b0, ocnt_q} + {2'b00, opush};
	assign em_issue   = em_act_q && ((occ < 3'd2) || ((occ == 3'd2) && opop));
	assign rd_en      = scan_issue || em_issue;
	assign rd_addr    = em_issue ? em_addr_q : scan_addr_q;
	assign res_scan   = rd_v_s1 && !rd_emit_s1 && (st_q == ST_SCAN);
	assign d_star     = rd_data_s1[9];
	assign d_space    = rd_data_s1[8];

	assign tx.valid        = (ocnt_q != 2'd0);
	assign tx.frame_byte   = ofifo_q[orp_q].data;
	assign tx.last_byte    = ofifo_q[orp_q].last;
	assign tx.good_frames  = good_q;
	assign tx.error_count  = err_q;
	assign tx.frame_offset = off_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_RUN;
			phase_q     <= PH_FIRST;
			wp_q        <= '0;
			fill_q      <= '0;
			pos_q       <= '0;
			good_q      <= '0;
			err_q       <= '0;
			off_q       <= '0;
			prev_cr_q   <= 1'b0;
			end_ok_q    <= 1'b0;
			scan_idx_q  <= '0;
			scan_addr_q <= '0;
			em_act_q    <= 1'b0;
			em_cnt_q    <= '0;
			em_addr_q   <= '0;
			rd_v_s1     <= 1'b0;
			rd_emit_s1  <= 1'b0;
			owp_q       <= 1'b0;
			orp_q       <= 1'b0;
			ocnt_q      <= 2'd0;
		end else begin
			rd_v_s1    <= rd_en;
			rd_emit_s1 <= em_issue;

			if (opush) begin
				owp_q <= !owp_q;
			end
			if (opop) begin
				orp_q <= !orp_q;
			end
			if (opush && !opop) begin
				ocnt_q <= ocnt_q + 2'd1;
			end else if (!opush && opop) begin
				ocnt_q <= ocnt_q - 2'd1;
			end

			if (em_issue) begin
				em_cnt_q  <= em_cnt_q + 1'b1;
				em_addr_q <= wrap_inc(em_addr_q);
				if (em_cnt_q == LAST_C) begin
					em_act_q <= 1'b0;
				end
			end

			if (pop) begin
				wp_q      <= wrap_inc(wp_q);
				fill_q    <= fill_q + 1'b1;
				pos_q     <= pos_q + 32'd1;
				prev_cr_q <= q_data.is_cr;
				if (fill_q == LAST_C) begin
					end_ok_q <= prev_cr_q && q_data.is_lf;
					st_q     <= ST_WAIT;
				end
			end

			if ((st_q == ST_WAIT) && (ocnt_q == 2'd0) && !rd_v_s1) begin
				st_q        <= ST_SCAN;
				phase_q     <= PH_FIRST;
				scan_idx_q  <= '0;
				scan_addr_q <= wp_q;
			end

			if (scan_issue) begin
				scan_idx_q  <= scan_idx_q + 1'b1;
				scan_addr_q <= wrap_inc(scan_addr_q);
			end

			if (res_scan) begin
				unique case (phase_q)
					PH_FIRST: begin
						if (d_star) begin
							if (rd_idx_s1 == '0) begin
								phase_q <= PH_LEAD;
							end else begin
								fill_q <= LEN_C - CW'(rd_idx_s1);
								st_q   <= ST_RUN;
							end
						end else if (rd_idx_s1 == LAST_I) begin
							fill_q <= '0;
							st_q   <= ST_RUN;
						end
					end
					PH_LEAD: begin
						if (d_space && end_ok_q) begin
							good_q    <= good_q + 32'd1;
							off_q     <= pos_q - LEN_32;
							fill_q    <= '0;
							em_act_q  <= 1'b1;
							em_cnt_q  <= '0;
							em_addr_q <= wp_q;
							st_q      <= ST_RUN;
						end else begin
							err_q <= err_q + 32'd1;
							if (d_star) begin
								fill_q <= LEN_C - CW'(rd_idx_s1);
								st_q   <= ST_RUN;
							end else begin
								phase_q <= PH_NEXT;
							end
						end
					end
					PH_NEXT: begin
						if (d_star) begin
							fill_q <= LEN_C - CW'(rd_idx_s1);
							st_q   <= ST_RUN;
						end else if (rd_idx_s1 == LAST_I) begin
							fill_q <= '0;
							st_q   <= ST_RUN;
						end
					end
					default: begin
						phase_q <= PH_FIRST;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			mem[wp_q] <= {q_data.is_star, q_data.is_space, q_data.data};
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
			rd_idx_s1  <= scan_idx_q[IW-1:0];
			rd_last_s1 <= (em_cnt_q == LAST_C);
		end
		if (opush) begin
			ofifo_q[owp_q] <= '{data: rd_data_s1[7:0], last: rd_last_s1};
		end
	end

endmodule

// ----- src/fixed_length_frame_sync.sv -----
// Fixed-length frame synchronizer: bytes enter one per transfer and fill a FRAME_LEN-byte
// ring buffer; a frame that starts with "* " and ends with CR LF is sent out byte by byte
// together with the good-frame count, the error count and its stream offset. Bytes are
// taken one per cycle, while the back end accepts them, through a front register and a
// four-entry queue. When the buffer fills, the back end waits for any earlier frame to
// leave its output buffer and then scans the memory one entry per cycle while the queue
// holds further input. A valid frame leaves at one byte per cycle while the output is
// accepted, set by the single memory read port, and refilling runs alongside it.
// Depends on fls_pkg, fls_if, fls_front, fls_fifo and fls_back.
module fixed_length_frame_sync #(
	parameter int FRAME_LEN = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	fls_byte_if.sink     rx,
	fls_frame_if.source  tx
);

	logic                 fq_valid;
	logic                 fq_ready;
	fls_pkg::byte_class_t fq_data;
	logic                 bq_valid;
	logic                 bq_ready;
	fls_pkg::byte_class_t bq_data;

	fls_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.rx      (rx),
		.q_valid (fq_valid),
		.q_ready (fq_ready),
		.q_data  (fq_data)
	);

	fls_fifo #(
		.DEPTH (fls_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_data  (fq_data),
		.pop_valid  (bq_valid),
		.pop_ready  (bq_ready),
		.pop_data   (bq_data)
	);

	fls_back #(
		.FRAME_LEN (FRAME_LEN)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (bq_valid),
		.q_ready (bq_ready),
		.q_data  (bq_data),
		.tx      (tx)
	);

endmodule
